### rtl/core/lms_pkg.sv
package lms_pkg;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_STICK_THRESHOLD = 2'd0,
    REG_STAND_DELAY     = 2'd1,
    REG_REMOTE_TIMEOUT  = 2'd2
  } reg_idx_t;

  // Event kinds of an input request
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_HOST   = 2'd1,
    OP_REMOTE = 2'd2
  } op_t;

  // Robot commands
  typedef enum logic [2:0] {
    CMD_STAND = 3'd0,
    CMD_WALK  = 3'd1,
    CMD_SIT   = 3'd2,
    CMD_STOP  = 3'd3,
    CMD_MOVE  = 3'd4
  } cmd_t;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [14:0] STICK_THRESHOLD_RST = 15'd1311;
  localparam logic [15:0] STAND_DELAY_RST     = 16'd200;
  localparam logic [15:0] REMOTE_TIMEOUT_RST  = 16'd50;

  // Result queue depth, a power of two of at least two
  localparam int unsigned QDEPTH = 4;

  typedef struct packed {
    logic [1:0]         opcode;
    logic               up_request;
    logic signed [15:0] forward_speed;
    logic signed [15:0] side_speed_in;
    logic signed [15:0] turn_speed_in;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [15:0]        key_mask;
  } in_t;

  typedef struct packed {
    cmd_t               command;
    logic signed [15:0] move_forward;
    logic signed [15:0] move_side;
    logic signed [15:0] move_turn;
    logic               last_of_run;
  } out_t;

  typedef struct packed {
    logic [14:0] stick_threshold;
    logic [15:0] stand_delay_ticks;
    logic [15:0] remote_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic               up_wanted;
    logic               up_seen_before;
    logic               stand_issued;
    logic               walk_issued;
    logic [15:0]        stand_ticks;
    logic               remote_busy;
    logic [15:0]        remote_age;
    logic signed [15:0] tgt_forward;
    logic signed [15:0] tgt_side;
    logic signed [15:0] tgt_turn;
  } state_t;

  // Results of one request: up to two commands
  typedef struct packed {
    logic [1:0] count;
    out_t       res0;
    out_t       res1;
  } step_res_t;

endpackage

### rtl/core/lms_step.sv
module lms_step
  import lms_pkg::*;
(
  input  in_t       item,
  input  state_t    state,
  input  cfg_t      cfg,
  output state_t    state_nxt,
  output step_res_t res
);

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    mag16 = v[15] ? (~v + 16'd1) : v;
  endfunction

  function automatic logic signed [15:0] neg_sat16(input logic signed [15:0] v);
    neg_sat16 = (v == 16'sh8000) ? 16'sh7FFF : (~v + 16'sd1);
  endfunction

  function automatic out_t mk_res(input cmd_t c, input state_t s);
    out_t r;
    r.command      = c;
    r.move_forward = (c == CMD_MOVE) ? s.tgt_forward : '0;
    r.move_side    = (c == CMD_MOVE) ? s.tgt_side    : '0;
    r.move_turn    = (c == CMD_MOVE) ? s.tgt_turn    : '0;
    r.last_of_run  = 1'b0;
    mk_res = r;
  endfunction

  logic [15:0] thr_ext;
  logic        moved;
  logic        key_held;
  logic [15:0] age_inc;
  logic        busy_tick;
  logic        rise;
  logic        fall;
  logic        stand_c;
  logic        walk_c;
  logic [15:0] ticks_inc;
  logic        walk_due;

  assign thr_ext  = {1'b0, cfg.stick_threshold};
  assign moved    = (mag16(item.left_x)  > thr_ext) || (mag16(item.left_y)  > thr_ext) ||
                    (mag16(item.right_x) > thr_ext) || (mag16(item.right_y) > thr_ext);
  assign key_held = |item.key_mask;

  // Age the remote activity and release it after the timeout
  assign age_inc   = (state.remote_age != 16'hFFFF) ? state.remote_age + 16'd1
                                                    : state.remote_age;
  assign busy_tick = state.remote_busy && !(age_inc > cfg.remote_timeout_ticks);

  assign rise    = state.up_wanted && !state.up_seen_before;
  assign fall    = !state.up_wanted && state.up_seen_before;
  assign stand_c = state.stand_issued && !(rise || fall);
  assign walk_c  = state.walk_issued && !(rise || fall);

  assign ticks_inc = (rise || fall) ? 16'd1 :
                     (state.stand_ticks != 16'hFFFF) ? state.stand_ticks + 16'd1
                                                     : state.stand_ticks;
  assign walk_due  = !walk_c && (ticks_inc >= cfg.stand_delay_ticks);

  always_comb begin
    state_nxt = state;
    res.count = 2'd0;
    res.res0  = mk_res(CMD_STOP, state);
    res.res1  = mk_res(CMD_STOP, state);

    case (op_t'(item.opcode))
      OP_TICK: begin
        if (state.remote_busy) begin
          state_nxt.remote_age  = age_inc;
          state_nxt.remote_busy = busy_tick;
        end
        if (rise || fall) begin
          state_nxt.stand_issued = 1'b0;
          state_nxt.walk_issued  = 1'b0;
          state_nxt.stand_ticks  = '0;
        end
        state_nxt.up_seen_before = state.up_wanted;

        if (fall) begin
          res.count = 2'd2;
          res.res0  = mk_res(CMD_STOP, state);
          res.res1  = mk_res(CMD_SIT, state);
        end else if (state.up_wanted) begin
          if (!stand_c) begin
            res.count              = 2'd1;
            res.res0               = mk_res(CMD_STAND, state);
            state_nxt.stand_issued = 1'b1;
            state_nxt.stand_ticks  = '0;
          end else begin
            state_nxt.stand_ticks = ticks_inc;
            if (walk_due) begin
              res.count             = 2'd1;
              res.res0              = mk_res(CMD_WALK, state);
              state_nxt.walk_issued = 1'b1;
            end else if (walk_c) begin
              res.count = 2'd1;
              res.res0  = mk_res(busy_tick ? CMD_STOP : CMD_MOVE, state);
            end
          end
        end

        // Mark the final command of the run
        if (res.count == 2'd2) begin
          res.res1.last_of_run = 1'b1;
        end else begin
          res.res0.last_of_run = 1'b1;
        end
      end
      OP_HOST: begin
        state_nxt.up_wanted   = item.up_request;
        state_nxt.tgt_forward = item.forward_speed;
        state_nxt.tgt_side    = neg_sat16(item.side_speed_in);
        state_nxt.tgt_turn    = neg_sat16(item.turn_speed_in);
      end
      OP_REMOTE: begin
        if (moved || key_held) begin
          state_nxt.remote_busy = 1'b1;
          state_nxt.remote_age  = '0;
        end
      end
      default: begin
        state_nxt = state;
      end
    endcase
  end

endmodule

### rtl/core/legged_motion_supervisor_core.sv
// Output: an accepted request's commands are registered in the result queue and appear
// on out_ behind any earlier ones. Throughput: one request per cycle while the queue has
// room for two commands; the single output port delivers one command per cycle while
// out_ready is high, so a tick giving two commands holds the port for both in turn.
// Reset (rst_n low, synchronous): supervisor state and queue cleared, configuration
// registers back to their defaults.
module legged_motion_supervisor_core
  import lms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,

  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned PTR_W = $clog2(QDEPTH);
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  // Configuration registers
  cfg_t cfg_r;

  // Supervisor state: host targets, up/down sequencing, remote activity
  state_t    state_r;
  state_t    state_nxt;
  step_res_t step_res;

  // Result queue: a request pushes zero, one or two commands
  out_t             queue_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic accept;
  logic pop;
  logic [1:0] push_n;

  lms_step u_step (
    .item      (in_data),
    .state     (state_r),
    .cfg       (cfg_r),
    .state_nxt (state_nxt),
    .res       (step_res)
  );

  // Take a request only when the queue can hold its worst case of two commands
  assign in_ready  = (count_r <= CNT_W'(QDEPTH - 2));
  assign accept    = in_valid && in_ready;
  assign out_valid = (count_r != '0);
  assign out_data  = queue_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign push_n    = accept ? step_res.count : 2'd0;
  assign count_nxt = count_r + CNT_W'(push_n) - CNT_W'(pop);

  // Configuration writes; ignore indexes beyond the register list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stick_threshold      <= STICK_THRESHOLD_RST;
      cfg_r.stand_delay_ticks    <= STAND_DELAY_RST;
      cfg_r.remote_timeout_ticks <= REMOTE_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_STICK_THRESHOLD: cfg_r.stick_threshold      <= cfg_wdata[14:0];
        REG_STAND_DELAY:     cfg_r.stand_delay_ticks    <= cfg_wdata;
        REG_REMOTE_TIMEOUT:  cfg_r.remote_timeout_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance the supervisor state on every accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  // Queue payload: write the first command at the tail, the second just after it
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue_r[wr_ptr_r] <= step_res.res0;
    end
    if (push_n == 2'd2) begin
      queue_r[wr_ptr_r + PTR_W'(1)] <= step_res.res1;
    end
  end

endmodule
